[rtl/fat32_cluster_chain_read_planner_assert.svh]
// Assertion macros for the cluster chain read planner.
// Expects signals named clk and arst_n in the module that uses them.
`ifndef FAT32_CLUSTER_CHAIN_READ_PLANNER_ASSERT_SVH
`define FAT32_CLUSTER_CHAIN_READ_PLANNER_ASSERT_SVH
`ifndef SYNTHESIS
`define CCRP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CCRP_ASSERT_NEVER(label, cond, msg) \
	`CCRP_ASSERT(label, !(cond), msg)
`else
`define CCRP_ASSERT(label, prop, msg)
`define CCRP_ASSERT_NEVER(label, cond, msg)
`endif
`endif

[rtl/ccrp_pkg.sv]
// Shared types and constants of the cluster chain read planner.
// No dependencies.
package ccrp_pkg;

	localparam int SECTOR_BYTES    = 512;
	localparam int SECTOR_LOG2     = $clog2(SECTOR_BYTES);
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam logic [27:0] FAT_END_MIN = 28'hFFFFFF8;

	typedef enum logic [1:0] {
		REG_FAT_START  = 2'd0,
		REG_DATA_START = 2'd1,
		REG_CLUSTER_LG = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		CMD_FETCH = 2'd0,
		CMD_RUN   = 2'd1,
		CMD_DONE  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SKIP,
		PH_READ
	} phase_t;

	typedef enum logic {
		SQ_DECIDE,
		SQ_TAIL
	} seq_t;

	typedef struct packed {
		logic [31:0] fat_start;
		logic [31:0] data_start;
		logic [2:0]  cluster_size_log2;
	} cfg_t;

	// decoded item as it waits in the queue
	typedef struct packed {
		logic        is_start;
		logic        no_data;
		logic [27:0] cluster;
		logic [31:0] length;
		logic [24:0] skip;
		logic [15:0] offset;
	} action_t;

	typedef struct packed {
		cmd_t        command;
		logic [31:0] sector_address;
		logic [15:0] byte_offset;
		logic [16:0] byte_count;
		logic [31:0] total_bytes;
		logic        last;
	} result_t;

endpackage

[rtl/ccrp_in_if.sv]
// Input channel of the cluster chain read planner: valid/ready plus item fields.
// No dependencies.
interface ccrp_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [27:0] first_cluster;
	logic [31:0] file_bytes;
	logic [31:0] read_offset;
	logic [31:0] read_length;
	logic [31:0] fat_word;

	modport source (output valid, op, first_cluster, file_bytes, read_offset,
		read_length, fat_word, input ready);
	modport sink (input valid, op, first_cluster, file_bytes, read_offset,
		read_length, fat_word, output ready);
endinterface

[rtl/ccrp_out_if.sv]
// Result channel of the cluster chain read planner: valid/ready plus result fields.
// No dependencies.
interface ccrp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] sector_address;
	logic [15:0] byte_offset;
	logic [16:0] byte_count;
	logic [31:0] total_bytes;
	logic        last;

	modport source (output valid, command, sector_address, byte_offset, byte_count,
		total_bytes, last, input ready);
	modport sink (input valid, command, sector_address, byte_offset, byte_count,
		total_bytes, last, output ready);
endinterface

[rtl/fat32_cluster_chain_read_planner.sv]
// Top level of the FAT32 cluster chain read planner.
// Depends on ccrp_pkg, ccrp_in_if, ccrp_out_if, ccrp_front, ccrp_queue, ccrp_back.
//
// Usage:
//  - req carries items: op 0 starts a read (first_cluster, file_bytes,
//    read_offset, read_length), op 1 returns a FAT word for the last fetch.
//  - rsp carries commands: FAT fetch, data run, or done with the byte total.
//    last marks the final command caused by one item. An item causes zero,
//    one or two commands (a run followed by a fetch or by done).
//  - cfg_we/cfg_index/cfg_data write the FAT start, data start and cluster
//    size registers; write them only while no request is in flight.
// Timing: an item is written into the queue, then its first command into the result
//  register. The back end emits one command per cycle while the output is not held,
//  so single-command items flow at one per cycle; a two-command item takes no new
//  item while its second command issues. The front end decodes into a QUEUE_DEPTH
//  entry queue and keeps accepting while the back end works or the output is held.
// Reset: arst_n clears the queue, the result valid flag and the walk state;
//  configuration registers return to zero.
// Stall: when rsp.ready is low the result register holds, the back end stops,
//  and req.ready drops once the queue is full.
module fat32_cluster_chain_read_planner #(
	parameter int QUEUE_DEPTH = ccrp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ccrp_in_if.sink     req,
	ccrp_out_if.source  rsp,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import ccrp_pkg::*;

	cfg_t    cfg_q;
	logic    push;
	logic    full;
	logic    pop;
	logic    head_valid;
	action_t act;
	action_t head;

	// configuration registers; an index past the list is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FAT_START:  cfg_q.fat_start         <= cfg_data;
				REG_DATA_START: cfg_q.data_start        <= cfg_data;
				REG_CLUSTER_LG: cfg_q.cluster_size_log2 <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// front: decode and clamp each item
	ccrp_front u_front (
		.req  (req),
		.cfg  (cfg_q),
		.full (full),
		.push (push),
		.act  (act)
	);

	// queue between the halves
	ccrp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_data   (act),
		.pop       (pop),
		.rd_data   (head),
		.not_empty (head_valid),
		.full      (full)
	);

	// back: chain walk and command issue
	ccrp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.rsp        (rsp)
	);

endmodule

[rtl/ccrp_front.sv]
// Front end: accepts items, clamps the request and splits the offset.
// Depends on ccrp_pkg and ccrp_in_if.
module ccrp_front (
	ccrp_in_if.sink           req,
	input  ccrp_pkg::cfg_t    cfg,
	input  logic              full,
	output logic              push,
	output ccrp_pkg::action_t act
);
	import ccrp_pkg::*;

	logic [32:0] end_pos;
	logic [31:0] clus_mask;
	logic        past_end;

	assign req.ready = !full;
	assign push      = req.valid && !full;

	always_comb begin
		end_pos   = {1'b0, req.read_offset} + {1'b0, req.read_length};
		clus_mask = (32'(SECTOR_BYTES) << cfg.cluster_size_log2) - 32'd1;
		past_end  = req.read_offset >= req.file_bytes;

		act.is_start = !req.op;
		act.no_data  = past_end || (req.read_length == 32'd0);
		act.cluster  = req.op ? req.fat_word[27:0] : req.first_cluster;
		// clamp to the end of the file
		act.length   = (end_pos > {1'b0, req.file_bytes}) ?
			(req.file_bytes - req.read_offset) : req.read_length;
		act.skip     = 25'((req.read_offset >> SECTOR_LOG2) >> cfg.cluster_size_log2);
		act.offset   = 16'(req.read_offset & clus_mask);
	end

endmodule

[rtl/ccrp_queue.sv]
// Small FIFO of decoded items between front and back end.
// Depends on ccrp_pkg and the assertion macro header.
`include "fat32_cluster_chain_read_planner_assert.svh"
module ccrp_queue #(
	parameter int DEPTH = ccrp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ccrp_pkg::action_t wr_data,
	input  logic              pop,
	output ccrp_pkg::action_t rd_data,
	output logic              not_empty,
	output logic              full
);
	import ccrp_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	action_t         mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign rd_data   = mem_q[rd_ptr_q];
	assign not_empty = count_q != CW'(0);
	assign full      = count_q == CW'(DEPTH);

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? PW'(0) : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	`CCRP_ASSERT(a_q_count_range, count_q <= CW'(DEPTH), "queue count beyond depth")
	`CCRP_ASSERT_NEVER(a_q_overflow, push && full, "push into full queue")
	`CCRP_ASSERT_NEVER(a_q_underflow, pop && !not_empty, "pop from empty queue")

endmodule

[rtl/ccrp_back.sv]
// Back end: walks the cluster chain state and issues commands into the result register.
// Depends on ccrp_pkg, ccrp_out_if and the assertion macro header.
`include "fat32_cluster_chain_read_planner_assert.svh"
module ccrp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ccrp_pkg::cfg_t    cfg,
	input  ccrp_pkg::action_t head,
	input  logic              head_valid,
	output logic              pop,
	ccrp_out_if.source        rsp
);
	import ccrp_pkg::*;

	seq_t        seq_q, seq_d;
	phase_t      phase_q, phase_d;
	logic [27:0] cluster_q;
	logic [24:0] skip_q;
	logic [15:0] off_q;
	logic [31:0] rest_q;
	logic [31:0] done_q;
	logic        fin_q;
	logic        rsp_valid_q;
	result_t     rsp_q;

	logic        adv;
	logic        is_end;
	logic [24:0] skip_dec;
	logic        act_load, act_fetch, act_run, act_done0, act_done_tot;
	logic [15:0] eff_off;
	logic [31:0] eff_rest;
	logic [31:0] eff_done;
	logic [16:0] bpc;
	logic [16:0] avail;
	logic        run_fin;
	logic [16:0] chunk;
	logic [31:0] run_sector;
	logic        emit;
	result_t     res;

	function automatic result_t fetch_res(input logic [31:0] base,
			input logic [27:0] clus);
		result_t r;
		r = '0;
		r.command        = CMD_FETCH;
		r.sector_address = base + 32'(clus >> (SECTOR_LOG2 - 2));
		r.byte_offset    = 16'({clus, 2'b00} & 30'(SECTOR_BYTES - 1));
		r.last           = 1'b1;
		return r;
	endfunction

	function automatic result_t done_res(input logic [31:0] total);
		result_t r;
		r = '0;
		r.command     = CMD_DONE;
		r.total_bytes = total;
		r.last        = 1'b1;
		return r;
	endfunction

	assign adv = !rsp_valid_q || rsp.ready;
	assign pop = (seq_q == SQ_DECIDE) && head_valid && adv;

	// classify the head item against the walk state
	always_comb begin
		is_end       = head.cluster >= FAT_END_MIN;
		skip_dec     = skip_q - 25'd1;
		act_load     = 1'b0;
		act_fetch    = 1'b0;
		act_run      = 1'b0;
		act_done0    = 1'b0;
		act_done_tot = 1'b0;
		if (head.is_start) begin
			act_load = !head.no_data;
			if (head.no_data) begin
				act_done0 = 1'b1;
			end else if (head.skip != 25'd0) begin
				act_fetch = 1'b1;
			end else if (is_end) begin
				act_done0 = 1'b1;
			end else begin
				act_run = 1'b1;
			end
		end else begin
			unique case (phase_q)
				PH_SKIP: begin
					if (is_end) begin
						act_done0 = 1'b1;
					end else if (skip_dec != 25'd0) begin
						act_fetch = 1'b1;
					end else begin
						act_run = 1'b1;
					end
				end
				PH_READ: begin
					act_done_tot = is_end;
					act_run      = !is_end;
				end
				default: ;
			endcase
		end
	end

	// data run arithmetic; a start item brings its own offset and length
	always_comb begin
		eff_off    = head.is_start ? head.offset : off_q;
		eff_rest   = head.is_start ? head.length : rest_q;
		eff_done   = head.is_start ? 32'd0 : done_q;
		bpc        = 17'(SECTOR_BYTES) << cfg.cluster_size_log2;
		avail      = bpc - 17'(eff_off);
		run_fin    = eff_rest <= 32'(avail);
		chunk      = run_fin ? eff_rest[16:0] : avail;
		run_sector = cfg.data_start
			+ ((32'(head.cluster) - 32'd2) << cfg.cluster_size_log2)
			+ 32'(eff_off >> SECTOR_LOG2);
	end

	// next state of the sequencer and of the walk phase
	always_comb begin
		seq_d   = seq_q;
		phase_d = phase_q;
		unique case (seq_q)
			SQ_DECIDE: begin
				if (pop) begin
					if (act_run) begin
						seq_d   = SQ_TAIL;
						phase_d = run_fin ? PH_IDLE : PH_READ;
					end else if (act_fetch) begin
						phase_d = PH_SKIP;
					end else if (act_done0 || act_done_tot) begin
						phase_d = PH_IDLE;
					end
				end
			end
			SQ_TAIL: begin
				if (adv) begin
					seq_d = SQ_DECIDE;
				end
			end
			default: seq_d = SQ_DECIDE;
		endcase
	end

	// result selection
	always_comb begin
		emit = 1'b0;
		res  = '0;
		unique case (seq_q)
			SQ_DECIDE: begin
				emit = pop && (act_fetch || act_run || act_done0 || act_done_tot);
				if (act_fetch) begin
					res = fetch_res(cfg.fat_start, head.cluster);
				end else if (act_run) begin
					res.command        = CMD_RUN;
					res.sector_address = run_sector;
					res.byte_offset    = eff_off;
					res.byte_count     = chunk;
				end else if (act_done_tot) begin
					res = done_res(done_q);
				end else begin
					res = done_res(32'd0);
				end
			end
			SQ_TAIL: begin
				emit = adv;
				res  = fin_q ? done_res(done_q) : fetch_res(cfg.fat_start, cluster_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= SQ_DECIDE;
			phase_q     <= PH_IDLE;
			rsp_valid_q <= 1'b0;
			cluster_q   <= '0;
			skip_q      <= '0;
			off_q       <= '0;
			rest_q      <= '0;
			done_q      <= '0;
			fin_q       <= 1'b0;
		end else begin
			seq_q   <= seq_d;
			phase_q <= phase_d;
			if (adv) begin
				rsp_valid_q <= emit;
			end
			if (pop) begin
				if (act_run) begin
					// run planned: offset is used up, totals move on
					cluster_q <= head.cluster;
					off_q     <= 16'd0;
					rest_q    <= eff_rest - 32'(chunk);
					done_q    <= eff_done + 32'(chunk);
					fin_q     <= run_fin;
				end else if (act_load) begin
					cluster_q <= head.cluster;
					skip_q    <= head.skip;
					off_q     <= head.offset;
					rest_q    <= head.length;
					done_q    <= 32'd0;
				end else if (head.is_start) begin
					done_q <= 32'd0;
				end else if (phase_q == PH_SKIP && !is_end) begin
					cluster_q <= head.cluster;
					skip_q    <= skip_dec;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.command        = rsp_q.command;
	assign rsp.sector_address = rsp_q.sector_address;
	assign rsp.byte_offset    = rsp_q.byte_offset;
	assign rsp.byte_count     = rsp_q.byte_count;
	assign rsp.total_bytes    = rsp_q.total_bytes;
	assign rsp.last           = rsp_q.last;

	`CCRP_ASSERT(a_tail_has_pending, seq_q == SQ_TAIL |-> rsp_valid_q,
		"second command without the first one pending")
	`CCRP_ASSERT(a_skip_nonzero, phase_q == PH_SKIP |-> skip_q != 25'd0,
		"skip phase with nothing left to skip")
	`CCRP_ASSERT(a_fin_idles, (seq_q == SQ_TAIL && fin_q) |-> phase_q == PH_IDLE,
		"finished run left the walk active")
	`CCRP_ASSERT(a_tail_after_run, seq_q == SQ_TAIL && $past(seq_q) == SQ_DECIDE
		|-> rsp_q.command == CMD_RUN, "second command not preceded by a run")

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for fat32_cluster_chain_read_planner: directed table, then random
// read requests with FAT-chain replies, checked against an in-bench command planner.
// Depends on ccrp_pkg, ccrp_in_if, ccrp_out_if and the RTL of the block.
module tb;
	import ccrp_pkg::*;

	localparam logic OP_START = 1'b0;
	localparam logic OP_FAT   = 1'b1;
	localparam logic [27:0] END_OF_CHAIN = 28'hFFFFFF8;
	localparam logic [27:0] BAD_CLUSTER  = 28'hFFFFFF7;
	localparam int RANDOM_ITEMS   = 1080;
	localparam int CFG_EVERY      = 215;
	localparam int SETTLE_CYCLES  = 16;   // covers the queue, the result register and slack
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef struct packed {
		logic        op;
		logic [27:0] first_cluster;
		logic [31:0] file_bytes;
		logic [31:0] read_offset;
		logic [31:0] read_length;
		logic [31:0] fat_word;
	} chain_item_t;

	// one directed row: the item, and optionally the commands typed in by hand
	typedef struct packed {
		chain_item_t it;
		logic        typed;
		logic [1:0]  n;
		result_t     r0;
		result_t     r1;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	ccrp_in_if  req_ch ();
	ccrp_out_if rsp_ch ();

	fat32_cluster_chain_read_planner dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Planner copy: configuration and walk state, as the block holds them
	// ---------------------------------------------------------------
	logic [31:0] cfg_fat        = '0;
	logic [31:0] cfg_data_start = '0;
	logic [2:0]  cfg_lg         = '0;

	phase_t      walk_phase    = PH_IDLE;
	logic [27:0] walk_cluster  = '0;
	logic [24:0] walk_skip     = '0;
	logic [15:0] walk_off      = '0;
	logic [31:0] want_bytes    = '0;
	logic [31:0] planned_bytes = '0;

	result_t planned_cmds[$];   // commands the block owes us, oldest first
	int      fail_count = 0;

	// shared between the item driver and the monitor
	logic    typed_on = 1'b0;
	logic [1:0] typed_n = '0;
	result_t typed_r0, typed_r1;
	logic    hold_req = 1'b0;   // asks the receiver for one long hold-off
	logic    calm     = 1'b0;   // no idling on either side while set

	function automatic result_t fetch_res(input logic [31:0] sec, input logic [15:0] off);
		result_t r;
		r = '0;
		r.command = CMD_FETCH;
		r.sector_address = sec;
		r.byte_offset = off;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic result_t run_res(input logic [31:0] sec, input logic [15:0] off,
			input logic [16:0] cnt);
		result_t r;
		r = '0;
		r.command = CMD_RUN;
		r.sector_address = sec;
		r.byte_offset = off;
		r.byte_count = cnt;
		return r;
	endfunction

	function automatic result_t done_res(input logic [31:0] total);
		result_t r;
		r = '0;
		r.command = CMD_DONE;
		r.total_bytes = total;
		r.last = 1'b1;
		return r;
	endfunction

	// FAT entry of the current cluster: 4 bytes per entry, 512 per sector
	function automatic result_t fetch_here();
		logic [31:0] ofs;
		ofs = {2'b00, walk_cluster, 2'b00};
		return fetch_res(cfg_fat + {9'b0, ofs[31:9]}, {7'b0, ofs[8:0]});
	endfunction

	function automatic result_t finish_walk(input logic [31:0] total);
		walk_phase = PH_IDLE;
		return done_res(total);
	endfunction

	// data run for the current cluster, then done or the next fetch
	function automatic void plan_run(output result_t r0, output result_t r1);
		logic [31:0] bpc, avail, rest, chunk, sec;
		bpc   = 32'd512 << cfg_lg;
		avail = bpc - {16'b0, walk_off};
		rest  = want_bytes - planned_bytes;
		chunk = (rest < avail) ? rest : avail;
		// cluster numbering starts at two; sums wrap at 32 bits
		sec = cfg_data_start + (({4'b0, walk_cluster} - 32'd2) << cfg_lg)
			+ {25'b0, walk_off[15:9]};
		r0 = run_res(sec, walk_off, chunk[16:0]);
		planned_bytes = planned_bytes + chunk;
		walk_off = '0;
		if (planned_bytes >= want_bytes) begin
			r1 = finish_walk(planned_bytes);
		end else begin
			walk_phase = PH_READ;
			r1 = fetch_here();
		end
	endfunction

	// Commands caused by one accepted item; returns how many (0..2).
	function automatic int plan_item(input chain_item_t it, output result_t r0,
			output result_t r1);
		logic [31:0] bpc, len, off32;
		logic [27:0] next;
		r0 = '0;
		r1 = '0;
		if (it.op == OP_START) begin
			bpc = 32'd512 << cfg_lg;
			planned_bytes = '0;
			if (it.read_offset >= it.file_bytes || it.read_length == 0) begin
				r0 = finish_walk('0);
				return 1;
			end
			len = it.read_length;
			if ({1'b0, it.read_offset} + {1'b0, len} > {1'b0, it.file_bytes})
				len = it.file_bytes - it.read_offset;
			want_bytes   = len;
			walk_cluster = it.first_cluster;
			walk_skip    = 25'(it.read_offset >> (32'd9 + cfg_lg));
			off32        = it.read_offset & (bpc - 32'd1);
			walk_off     = off32[15:0];
			if (walk_skip != 0) begin
				walk_phase = PH_SKIP;
				r0 = fetch_here();
				return 1;
			end
			if (walk_cluster >= END_OF_CHAIN) begin
				r0 = finish_walk('0);
				return 1;
			end
			plan_run(r0, r1);
			return 2;
		end
		next = it.fat_word[27:0];   // top nibble of a FAT32 entry is reserved
		if (walk_phase == PH_SKIP) begin
			if (next >= END_OF_CHAIN) begin
				r0 = finish_walk('0);
				return 1;
			end
			walk_cluster = next;
			walk_skip = walk_skip - 25'd1;
			if (walk_skip != 0) begin
				r0 = fetch_here();
				return 1;
			end
			plan_run(r0, r1);
			return 2;
		end
		if (walk_phase == PH_READ) begin
			if (next >= END_OF_CHAIN) begin
				r0 = finish_walk(planned_bytes);
				return 1;
			end
			walk_cluster = next;
			plan_run(r0, r1);
			return 2;
		end
		return 0;   // FAT word with no request open is dropped
	endfunction

	// ---------------------------------------------------------------
	// Monitor: predict on every accepted item, check every accepted command
	// ---------------------------------------------------------------
	chain_item_t seen_item;
	result_t     pred_a, pred_b, want;
	int          n_pred;

	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready) begin
			seen_item.op            = req_ch.op;
			seen_item.first_cluster = req_ch.first_cluster;
			seen_item.file_bytes    = req_ch.file_bytes;
			seen_item.read_offset   = req_ch.read_offset;
			seen_item.read_length   = req_ch.read_length;
			seen_item.fat_word      = req_ch.fat_word;
			n_pred = plan_item(seen_item, pred_a, pred_b);
			// hand-typed rows replace the planner's output, state still advances
			if (typed_on) begin
				if (typed_n > 0) planned_cmds.push_back(typed_r0);
				if (typed_n > 1) planned_cmds.push_back(typed_r1);
			end else begin
				if (n_pred > 0) planned_cmds.push_back(pred_a);
				if (n_pred > 1) planned_cmds.push_back(pred_b);
			end
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (planned_cmds.size() == 0) begin
				$error("unexpected command %0d, sector %h", rsp_ch.command,
					rsp_ch.sector_address);
				fail_count++;
			end else begin
				want = planned_cmds.pop_front();
				if (rsp_ch.command !== want.command) begin
					$error("command: expected %0d, got %0d", want.command, rsp_ch.command);
					fail_count++;
				end
				if (rsp_ch.sector_address !== want.sector_address) begin
					$error("sector_address: expected %h, got %h", want.sector_address,
						rsp_ch.sector_address);
					fail_count++;
				end
				if (rsp_ch.byte_offset !== want.byte_offset) begin
					$error("byte_offset: expected %0d, got %0d", want.byte_offset,
						rsp_ch.byte_offset);
					fail_count++;
				end
				if (rsp_ch.byte_count !== want.byte_count) begin
					$error("byte_count: expected %0d, got %0d", want.byte_count,
						rsp_ch.byte_count);
					fail_count++;
				end
				if (rsp_ch.total_bytes !== want.total_bytes) begin
					$error("total_bytes: expected %0d, got %0d", want.total_bytes,
						rsp_ch.total_bytes);
					fail_count++;
				end
				if (rsp_ch.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, rsp_ch.last);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: too long with no item moving on either channel ends the run.
	int stuck_cycles = 0;
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$error("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	// Receiver: random back-pressure, one long hold-off on request.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				rsp_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			rsp_ch.ready = calm || ($urandom_range(0, 99) >= 26);
		end
	end

	// ---------------------------------------------------------------
	// Sender side
	// ---------------------------------------------------------------
	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_item(input chain_item_t it);
		while (!calm && $urandom_range(0, 99) < 26) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid         = 1'b1;
		req_ch.op            = it.op;
		req_ch.first_cluster = it.first_cluster;
		req_ch.file_bytes    = it.file_bytes;
		req_ch.read_offset   = it.read_offset;
		req_ch.read_length   = it.read_length;
		req_ch.fat_word      = it.fat_word;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Stop offering, wait for every owed command, then let the pipe empty.
	task automatic drain(input int extra);
		req_ch.valid = 1'b0;
		while (planned_cmds.size() != 0) @(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	// Registers only change with the block idle. Upper bits of the lg write are junk.
	task automatic load_config(input logic [31:0] fat, input logic [31:0] data,
			input logic [2:0] lg);
		drain(SETTLE_CYCLES);
		cfg_we = 1'b1;
		cfg_index = REG_FAT_START;
		cfg_data = fat;
		@(negedge clk);
		cfg_index = REG_DATA_START;
		cfg_data = data;
		@(negedge clk);
		cfg_index = REG_CLUSTER_LG;
		cfg_data = {29'($urandom), lg};
		@(negedge clk);
		cfg_we = 1'b0;
		cfg_fat = fat;
		cfg_data_start = data;
		cfg_lg = lg;
	endtask

	function automatic chain_item_t start_item(input logic [27:0] cl, input logic [31:0] fsize,
			input logic [31:0] off, input logic [31:0] len);
		chain_item_t it;
		it = '0;
		it.op = OP_START;
		it.first_cluster = cl;
		it.file_bytes = fsize;
		it.read_offset = off;
		it.read_length = len;
		return it;
	endfunction

	function automatic chain_item_t fat_item(input logic [31:0] word);
		chain_item_t it;
		it = '0;
		it.op = OP_FAT;
		it.fat_word = word;
		return it;
	endfunction

	// Read request sized to a few clusters, so chains end in a handful of fetches.
	// A wild request has every field random.
	function automatic chain_item_t draw_start(input bit wild);
		chain_item_t it;
		logic [31:0] span, lim;
		int pick;
		if (wild)
			return start_item(28'($urandom), $urandom, $urandom, $urandom);
		it = start_item('0, '0, '0, '0);
		span = (32'd512 << cfg_lg) * $urandom_range(1, 6);
		pick = $urandom_range(0, 99);
		if (pick < 85)
			it.first_cluster = 28'($urandom_range(2, 32'h0FFFFFEF));
		else if (pick < 89)
			it.first_cluster = 28'($urandom_range(0, 1));
		else if (pick < 93)
			it.first_cluster = BAD_CLUSTER;
		else
			it.first_cluster = END_OF_CHAIN + 28'($urandom_range(0, 7));
		it.file_bytes = ($urandom_range(0, 99) < 90) ? $urandom_range(1, span) : $urandom;
		lim = (it.file_bytes != 0 && it.file_bytes < span) ? it.file_bytes : span;
		pick = $urandom_range(0, 99);
		if (pick < 88)
			it.read_offset = $urandom_range(0, lim - 1);
		else if (pick < 94)
			it.read_offset = it.file_bytes + $urandom_range(0, 3);   // at or past EOF
		else
			it.read_offset = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 80)
			it.read_length = $urandom_range(1, span);
		else if (pick < 88)
			it.read_length = '0;
		else
			it.read_length = 32'hFFFFFFFF;
		return it;
	endfunction

	// Next FAT entry as storage would return it; reserved nibble is random.
	function automatic logic [31:0] draw_link();
		int pick;
		logic [27:0] next;
		pick = $urandom_range(0, 99);
		if (pick < 12)
			next = END_OF_CHAIN + 28'($urandom_range(0, 7));
		else if (pick < 14)
			next = BAD_CLUSTER;
		else if (pick < 16)
			next = 28'($urandom_range(0, 1));
		else
			next = 28'($urandom_range(2, 32'h0FFFFFEF));
		return {4'($urandom), next};
	endfunction

	dir_row_t directed_rows[$];
	int       max_cfg_row;

	task automatic add_open(input chain_item_t it);
		dir_row_t row;
		row = '0;
		row.it = it;
		directed_rows.push_back(row);
	endtask

	task automatic add_typed(input chain_item_t it, input int n, input result_t r0,
			input result_t r1);
		dir_row_t row;
		row = '0;
		row.it = it;
		row.typed = 1'b1;
		row.n = 2'(n);
		row.r0 = r0;
		row.r1 = r1;
		directed_rows.push_back(row);
	endtask

	initial begin
		int count;
		int cfg_phase;
		bit hold_done;
		bit pause_done;
		bit counted;
		chain_item_t it;
		dir_row_t row;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_START;
		req_ch.first_cluster = '0;
		req_ch.file_bytes = '0;
		req_ch.read_offset = '0;
		req_ch.read_length = '0;
		req_ch.fat_word = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Directed table. Registers at reset: FAT and data at sector 0, 512-byte clusters.
		// zero length
		add_typed(start_item(28'd2, 32'd1000, 32'd0, 32'd0), 1, done_res('0), '0);
		// offset at end of a maximal file
		add_typed(start_item(28'd2, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd5), 1, done_res('0), '0);
		// FAT word with nothing open: dropped
		add_typed(fat_item(32'hFFFFFFFF), 0, '0, '0);
		// start cluster already end of chain, nothing to skip
		add_typed(start_item(28'hFFFFFFF, 32'd100, 32'd0, 32'd100), 1, done_res('0), '0);
		// single run that finishes the request
		add_typed(start_item(28'd2, 32'd1000, 32'd0, 32'd100), 2,
			run_res(32'd0, 16'd0, 17'd100), done_res(32'd100));
		// one cluster to skip: entry 5 sits at byte 20 of FAT sector 0
		add_typed(start_item(28'd5, 32'd2000, 32'd600, 32'd5000), 1,
			fetch_res(32'd0, 16'd20), '0);
		add_open(fat_item(32'hF0000009));                    // reserved bits set
		add_open(fat_item({4'h0, BAD_CLUSTER}));             // bad marker walked as a cluster
		add_open(fat_item(32'h00000000));                    // cluster 0: sector wraps
		add_open(start_item(28'd1, 32'd10000, 32'd0, 32'd2000));
		add_open(fat_item({4'h0, END_OF_CHAIN}));            // chain ends mid-read
		add_open(start_item(28'd3, 32'd10000, 32'd1024, 32'd100));
		add_open(fat_item(32'hFFFFFFFF));                    // chain ends while skipping
		// highest cluster: last entry of FAT sector 0x1FFFFF
		add_typed(start_item(28'hFFFFFFF, 32'hFFFFFFFF, 32'd1536, 32'hFFFFFFFF), 1,
			fetch_res(32'h001FFFFF, 16'd508), '0);
		// new requests abandon the open one; length clamped to the file
		add_open(start_item(28'd7, 32'hFFFFFFFF, 32'hFFFFFF00, 32'hFFFFFFFF));
		add_open(start_item(28'd0, 32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF));
		add_open(fat_item(32'h00000002));
		add_open(start_item(28'd2, 32'd1, 32'd0, 32'd1));
		// from here: top sectors and 64 KiB clusters
		max_cfg_row = directed_rows.size();
		add_typed(start_item(28'd2, 32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF), 2,
			run_res(32'hFFFFFFFF, 16'd0, 17'd65536), fetch_res(32'hFFFFFFFF, 16'd8));
		add_open(fat_item(32'h0FFFFFFE));
		add_open(start_item(28'hFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFE, 32'hFFFFFFFF));
		add_open(start_item(28'd2, 32'd70000, 32'd65535, 32'd10));   // last byte of a cluster
		add_open(fat_item(32'h00000003));

		for (int i = 0; i < directed_rows.size(); i++) begin
			if (i == max_cfg_row)
				load_config(32'hFFFFFFFF, 32'hFFFFFFFF, 3'd7);
			row = directed_rows[i];
			typed_on = row.typed;
			typed_n  = row.n;
			typed_r0 = row.r0;
			typed_r1 = row.r1;
			send_item(row.it);
		end
		typed_on = 1'b0;

		// Random part: mostly well-formed walks (request, then one FAT word per fetch),
		// with stray FAT words, abandoned walks and fully random requests mixed in.
		count = 0;
		cfg_phase = 0;
		hold_done = 1'b0;
		pause_done = 1'b0;
		while (count < RANDOM_ITEMS) begin
			if (count == cfg_phase * CFG_EVERY) begin
				case (cfg_phase)
					0: load_config($urandom, $urandom, 3'd0);
					1: load_config(32'hFFFFFFFF, 32'd0, 3'd7);
					2: load_config(32'd0, 32'hFFFFFFFF, 3'($urandom_range(0, 7)));
					default: load_config($urandom, $urandom, 3'($urandom_range(0, 7)));
				endcase
				cfg_phase++;
			end
			// receiver stalls long while we keep offering: queue fills, input stalls
			if (count >= 250 && !hold_done) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			// sender pause until the block has nothing left to say
			if (count >= 520 && !pause_done) begin
				drain(0);
				pause_done = 1'b1;
			end
			calm = (count >= 700 && count < 900);

			if (walk_phase == PH_IDLE)
				it = ($urandom_range(0, 99) < 6) ? fat_item($urandom)
					: draw_start($urandom_range(0, 99) < 4);
			else if (walk_skip > 16 || $urandom_range(0, 99) < 5)
				it = draw_start($urandom_range(0, 99) < 10);
			else
				it = fat_item(draw_link());
			counted = !(it.op == OP_FAT && walk_phase == PH_IDLE);
			send_item(it);
			if (counted)
				count++;
		end
		calm = 1'b0;

		drain(SETTLE_CYCLES);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
